// ===== rtl/rso_pkg.sv =====
// Package for the rank slot online selector.
// Holds sizes, register indexes, the controller state type and the cell control struct.
// Depends on nothing.
package rso_pkg;

    // Capacity of the sorted store (number of cells in the chain)
    localparam int MAX_ITEMS  = 128;
    // Number of rank slots that may each be filled once
    localparam int RANK_SLOTS = 128;
    localparam int SLOT_W     = $clog2(RANK_SLOTS);
    // Rank runs 0..MAX_ITEMS
    localparam int RANK_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W      = 32;
    localparam int SUM_W      = 39;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_COUNT = 2'd1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    // Control broadcast to every cell
    typedef struct packed {
        logic clear;   // drop all stored values (new run)
        logic cmp;     // register compare flags against the item value
        logic shift;   // insert: cells at and below the rank take their left neighbor
    } t_cell_ctrl;

endpackage

// ===== rtl/rso_cell.sv =====
// One cell of the sorted insert chain: holds one stored value and its valid bit.
// Compares against the broadcast item value and shifts in from its left neighbor.
// Depends on rso_pkg.
module rso_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rso_pkg::t_cell_ctrl       i_ctrl,
    input  logic [rso_pkg::VAL_W-1:0] i_value,
    input  logic [rso_pkg::VAL_W-1:0] i_left_val,
    input  logic                      i_left_valid,
    input  logic                      i_left_gt,
    output logic [rso_pkg::VAL_W-1:0] o_val,
    output logic                      o_valid,
    output logic                      o_gt,
    output logic                      o_eq
);
    import rso_pkg::*;

    logic [VAL_W-1:0] r_val;
    logic             r_valid;
    logic             r_gt;
    logic             r_eq;

    // Valid bit: cleared at reset and at the start of a run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift && !r_gt) begin
            r_valid <= i_left_gt | i_left_valid;
        end
    end

    // Stored value: the item lands where the left neighbor is still greater
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift && !r_gt) begin
            r_val <= i_left_gt ? i_value : i_left_val;
        end
    end

    // Compare flags, held for the update cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            r_gt <= r_valid && (r_val > i_value);
            r_eq <= r_valid && (r_val == i_value);
        end
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;

endmodule

// ===== rtl/rank_slot_online_selector.sv =====
// Rank slot online selector: sorted insert chain of cells plus slot and total logic.
// Flow: an accepted item passes the compare state, then the update state, which
// registers the result. The input takes an item only in the idle state, so a new item
// waits until the compare and update steps of the last one are done. A stalled output
// holds the update step, and with it the input, until the previous result is taken.
// Reset: synchronous active low; clears store, slots, counters, total and sets
// sample_count to 37 and select_count to 1. A first_of_run item clears the run state.
module rank_slot_online_selector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [rso_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rso_pkg::CFG_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_first_of_run,
    input  logic [31:0]                      i_value,
    // Output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic [7:0]                       o_rank,
    output logic [38:0]                      o_running_total,
    output logic                             o_overflow
);
    import rso_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] r_sample;
    logic [CFG_W-1:0] r_select;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= 8'd37;
            r_select <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_COUNT: r_sample <= i_cfg_data;
                CFG_SELECT_COUNT: r_select <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Controller
    t_state     r_state;
    t_state     n_state;
    t_cell_ctrl cell_ctrl;
    logic       in_acc;
    logic       out_free;
    logic       upd_go;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !o_out_valid || !i_out_stall;
    assign upd_go   = (r_state == ST_UPD) && out_free;
    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    logic ins;  // item goes into the store

    always_comb begin
        n_state         = r_state;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.cmp   = 1'b0;
        cell_ctrl.shift = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state         = ST_CMP;
                    cell_ctrl.clear = i_first_of_run;
                end
            end
            ST_CMP: begin
                cell_ctrl.cmp = 1'b1;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    cell_ctrl.shift = ins;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Item value held while the item is at work
    logic [VAL_W-1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v <= i_value;
        end
    end

    // Cell chain
    logic [VAL_W-1:0] cell_val   [MAX_ITEMS];
    logic             cell_valid [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] cell_gt;
    logic [MAX_ITEMS-1:0] cell_eq;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic             left_valid;
        logic             left_gt;
        if (g == 0) begin : g_head
            assign left_val   = r_v;
            assign left_valid = 1'b1;
            assign left_gt    = 1'b1;
        end else begin : g_body
            assign left_val   = cell_val[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_gt    = cell_gt[g-1];
        end
        rso_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_value      (r_v),
            .i_left_val   (left_val),
            .i_left_valid (left_valid),
            .i_left_gt    (left_gt),
            .o_val        (cell_val[g]),
            .o_valid      (cell_valid[g]),
            .o_gt         (cell_gt[g]),
            .o_eq         (cell_eq[g])
        );
    end

    // Rank: greater flags form a prefix, so encode the position of its edge
    logic [RANK_W-1:0] rank;

    always_comb begin
        rank = '0;
        for (int i = 1; i < MAX_ITEMS; i++) begin
            if (cell_gt[i-1] && !cell_gt[i]) begin
                rank = rank | RANK_W'(i);
            end
        end
        if (cell_gt[MAX_ITEMS-1]) begin
            rank = rank | RANK_W'(MAX_ITEMS);
        end
    end

    // Store fill count
    logic [RANK_W-1:0] r_count;
    logic              dup;
    logic              full;

    assign dup  = |cell_eq;
    assign full = (32'(r_count) == 32'(MAX_ITEMS));
    assign ins  = !dup && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc && i_first_of_run) begin
            r_count <= '0;
        end else if (upd_go && ins) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Slot selection
    logic [RANK_SLOTS-1:0] r_taken;
    logic [7:0]            r_seen;
    logic [SUM_W-1:0]      r_sum;
    logic [31:0]           rank_ext;
    logic [SLOT_W-1:0]     slot_idx;
    logic [CFG_W-1:0]      limit;
    logic                  sel;
    logic [SUM_W:0]        sum_add;
    logic [SUM_W-1:0]      sum_next;

    assign rank_ext = 32'(rank);
    assign slot_idx = rank_ext[SLOT_W-1:0];
    assign limit    = (32'(r_select) > 32'(RANK_SLOTS)) ? CFG_W'(RANK_SLOTS) : r_select;
    assign sel      = (r_seen >= r_sample) && (rank_ext < 32'(limit)) && !r_taken[slot_idx];
    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(r_v);
    assign sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (in_acc && i_first_of_run) begin
            r_taken <= '0;
            r_seen  <= '0;
            r_sum   <= '0;
        end else if (upd_go) begin
            if (sel) begin
                r_taken[slot_idx] <= 1'b1;
                r_sum             <= sum_next;
            end
            if (r_seen != 8'hFF) begin
                r_seen <= r_seen + 8'd1;
            end
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    logic              r_accepted;
    logic [7:0]        r_rank_out;
    logic [SUM_W-1:0]  r_total;
    logic              r_ovf;

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_accepted <= sel;
            r_rank_out <= (rank_ext > 32'd255) ? 8'hFF : rank_ext[7:0];
            r_total    <= sel ? sum_next : r_sum;
            r_ovf      <= !dup && full;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_rank          = r_rank_out;
    assign o_running_total = r_total;
    assign o_overflow      = r_ovf;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for rank_slot_online_selector: runs of items under several
// selection settings, each result checked against an in-bench model of the selector.
// Depends on rso_pkg and the selector RTL.
module testbench;
    import rso_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 150;
    // Indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [SUM_W-1:0] SUM_CAP = '1;
    localparam int N_DIRECTED = 16;

    typedef enum int {VAL_RANDOM, VAL_FEW, VAL_FALLING, VAL_EDGES} t_val_mode;

    typedef struct {
        bit          first;
        logic [31:0] value;
        bit          drain;   // hold this item until all results are back
    } t_sel_item;

    typedef struct {
        bit          accepted;
        logic [7:0]  rank;
        logic [38:0] total;
        bit          overflow;
    } t_pick;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_first_of_run = 1'b0;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_accepted;
    logic [7:0]  o_rank;
    logic [38:0] o_running_total;
    logic        o_overflow;

    // Selector model state
    logic [31:0]      kept_vals [MAX_ITEMS];
    int               kept_cnt = 0;
    bit               slot_taken [RANK_SLOTS];
    int               run_seen = 0;
    logic [SUM_W-1:0] run_total = '0;
    logic [7:0]       sample_cfg = 8'd37;
    logic [7:0]       select_cfg = 8'd1;

    t_sel_item pending_items[$];
    t_pick     expected_picks[$];

    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    int src_gap = 0;
    int snk_stall_left = 0;
    int hold_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int picks_accepted = 0;
    int picks_overflow = 0;
    int cfg_writes = 0;
    int cycles = 0;

    logic [31:0] directed_vals [N_DIRECTED] = '{
        32'h8000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h9000_0000, 32'h9000_0000, 32'h8800_0000,
        32'h8400_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
        32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFE
    };
    bit directed_first [N_DIRECTED] = '{
        1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0
    };

    rank_slot_online_selector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_first_of_run  (i_first_of_run),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_rank          (o_rank),
        .o_running_total (o_running_total),
        .o_overflow      (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Insert the value, rank it, and decide whether it fills a free top slot
    function automatic t_pick rank_and_select(bit first, logic [31:0] v);
        t_pick            res;
        int               r;
        int               k;
        int               lim;
        bit               dup;
        logic [SUM_W:0]   sum;
        if (first) begin
            foreach (slot_taken[i]) slot_taken[i] = 1'b0;
            kept_cnt  = 0;
            run_seen  = 0;
            run_total = '0;
        end
        r = 0;
        while (r < kept_cnt && kept_vals[r] > v) r++;
        dup = (r < kept_cnt) && (kept_vals[r] == v);
        res.overflow = 1'b0;
        if (!dup) begin
            if (kept_cnt >= MAX_ITEMS) begin
                res.overflow = 1'b1;
            end else begin
                for (k = kept_cnt; k > r; k--) kept_vals[k] = kept_vals[k-1];
                kept_vals[r] = v;
                kept_cnt++;
            end
        end
        lim = (select_cfg > RANK_SLOTS) ? RANK_SLOTS : int'(select_cfg);
        res.accepted = 1'b0;
        if (run_seen >= sample_cfg && r < lim && !slot_taken[r]) begin
            slot_taken[r] = 1'b1;
            res.accepted  = 1'b1;
            sum = {1'b0, run_total} + v;
            run_total = (sum > SUM_CAP) ? SUM_CAP : sum[SUM_W-1:0];
        end
        if (run_seen < 255) run_seen++;
        res.rank  = (r > 255) ? 8'd255 : 8'(r);
        res.total = run_total;
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // Input driver: takes items from the pending queue, predicts on accept
    always @(posedge i_clk) begin : drive_items
        bit        next_valid;
        t_sel_item it;
        t_pick     pred;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            next_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                pred = rank_and_select(i_first_of_run, i_value);
                expected_picks = {expected_picks, pred};
                items_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_picks.size() > 0)) begin
                    it = pending_items.pop_front();
                    i_first_of_run <= it.first;
                    i_value        <= it.value;
                    next_valid     = 1'b1;
                    src_gap        = pick_gap(src_idle_en);
                end
            end
            i_in_valid <= next_valid;
        end
    end

    // Result monitor and output stall generator
    always @(posedge i_clk) begin : watch_results
        t_pick want;
        bit    next_stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_picks.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = expected_picks.pop_front();
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("rank", want.rank, o_rank);
                    check_field("running_total", want.total, o_running_total);
                    check_field("overflow", want.overflow, o_overflow);
                end
                if (o_accepted === 1'b1) picks_accepted++;
                if (o_overflow === 1'b1) picks_overflow++;
                // long hold-off so the block backs up into its input
                if (results_seen == 120 || results_seen == 600) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_stall = 1'b1;
            end else if (snk_stall_left > 0) begin
                snk_stall_left--;
                next_stall = 1'b1;
            end else if (snk_idle_en && $urandom_range(0, 3) == 0) begin
                snk_stall_left = pick_gap(1'b1);
                next_stall = 1'b1;
            end else begin
                next_stall = 1'b0;
            end
            i_out_stall <= next_stall;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_picks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_picks.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_SAMPLE_COUNT) sample_cfg = data;
        else if (idx == CFG_SELECT_COUNT) select_cfg = data;
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic start_phase(logic [7:0] sample, logic [7:0] select, bit src_en, bit snk_en);
        wait_idle();
        write_reg(CFG_SAMPLE_COUNT, sample);
        write_reg(CFG_SELECT_COUNT, select);
        src_idle_en = src_en;
        snk_idle_en = snk_en;
    endtask

    // One run: usually opened by first_of_run, with an occasional stray restart
    task automatic queue_run(int len, t_val_mode mode);
        t_sel_item it;
        int        k;
        for (k = 0; k < len; k++) begin
            if (k == 0) it.first = ($urandom_range(0, 19) != 0);
            else        it.first = ($urandom_range(0, 59) == 0);
            case (mode)
                VAL_FEW:     it.value = $urandom & 32'h1F00_0000;
                VAL_FALLING: it.value = 32'hFFFF_FFFF - k * 32'h0100_0003;
                VAL_EDGES: begin
                    case ($urandom_range(0, 3))
                        0:       it.value = 32'h0000_0000;
                        1:       it.value = 32'hFFFF_FFFF;
                        2:       it.value = 32'h1 << $urandom_range(0, 31);
                        default: it.value = ~(32'h1 << $urandom_range(0, 31));
                    endcase
                end
                default:     it.value = $urandom;
            endcase
            it.drain = ($urandom_range(0, 79) == 0);
            pending_items = {pending_items, it};
        end
    endtask

    task automatic queue_runs(int n, int len_lo, int len_hi);
        int j;
        for (j = 0; j < n; j++) begin
            queue_run($urandom_range(len_lo, len_hi),
                      ($urandom_range(0, 9) < 5) ? VAL_RANDOM
                                                 : t_val_mode'($urandom_range(1, 3)));
        end
    endtask

    initial begin : stimulus
        t_sel_item it;
        int        j;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // settings out of reset
        queue_run(45, VAL_RANDOM);

        // directed: duplicates, taken slots, rank past the limit, extremes, restart
        start_phase(8'd2, 8'd3, 1'b0, 1'b0);
        for (j = 0; j < N_DIRECTED; j++) begin
            it.first = directed_first[j];
            it.value = directed_vals[j];
            it.drain = 1'b0;
            pending_items = {pending_items, it};
        end

        start_phase(8'd0, 8'd1, 1'b1, 1'b1);
        queue_runs(3, 15, 30);

        // falling values fill every slot and overrun the store
        start_phase(8'd0, 8'd128, 1'b1, 1'b0);
        queue_run(140, VAL_FALLING);
        queue_run(30, VAL_FEW);

        start_phase(8'd128, 8'd128, 1'b0, 1'b1);
        write_reg(CFG_SPARE_A, 8'($urandom));
        write_reg(CFG_SPARE_B, 8'($urandom));
        queue_run(140, VAL_RANDOM);

        start_phase(8'd10, 8'd5, 1'b1, 1'b1);
        queue_runs(3, 20, 40);

        // no slots at all
        start_phase(8'd5, 8'd0, 1'b1, 1'b1);
        queue_runs(2, 15, 25);

        // item counter saturates before anything can be picked
        start_phase(8'd255, 8'd255, 1'b1, 1'b1);
        queue_run(280, VAL_RANDOM);

        start_phase(8'd1, 8'd2, 1'b0, 1'b0);
        queue_runs(3, 10, 25);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("%0d items in, %0d results checked, %0d picked, %0d store overruns",
                 items_sent, results_seen, picks_accepted, picks_overflow);
        $display("%0d register writes across 9 settings, %0d cycles", cfg_writes, cycles);
        if (errors == 0 && expected_picks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
